FILE: hdl/mmf_pkg.sv
package mmf_pkg;

    // Sample width and the largest usable window.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WINDOW  = 9;

    // Width of the window size register and of the write pointer.
    localparam int WIN_BITS  = 4;
    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(5);

    // Bit position counter for the serial selection pass.
    localparam int BIT_CNT_W = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

    // Counts of entries, up to and including MAX_WINDOW.
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [MAX_WINDOW-1:0]         t_mask;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

FILE: hdl/moving_median_filter.sv
// Moving median over a sliding window of signed samples.
//
// Input channel (s_axis): one word per sample. Output channel (m_axis): one
// word per accepted sample, carrying the median of the current window, or
// zero when the window size register holds 0 or a value above the maximum
// window. Configuration channel (cfg): a single write-only register, the
// window size, always ready; write it only while the filter is idle.
//
// The output word turns valid once the selection pass is done. The
// sample is stored at the accepting edge itself, when the window size is
// valid. The bit-serial radix selection then takes one step per sample
// bit, walking every window entry from the sign bit down, and the done
// state hands the result to the output register once that register is
// free. The filter is back to idle at that same edge, and only then takes
// a new sample, so samples never overlap in the selection pass.
//
// Reset clears the window store to zero, the write pointer to slot zero and
// the window size to five, so early medians include those zeros. When the
// receiver stalls, the finished word waits in the output register; the
// filter still takes and processes the next sample, and holds its result
// until the output register frees up.
module moving_median_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words. tdata: sample[15:0].
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,
    // Output words. tdata: median[15:0].
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,
    // Window size register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    localparam int SB  = mmf_pkg::SAMPLE_BITS;
    localparam int MW  = mmf_pkg::MAX_WINDOW;
    localparam int WB  = mmf_pkg::WIN_BITS;
    localparam int BCW = mmf_pkg::BIT_CNT_W;
    localparam int CW  = mmf_pkg::CNT_W;

    mmf_pkg::t_state r_state, n_state;

    logic [WB-1:0]        r_win;
    logic [WB-1:0]        r_wslot;
    mmf_pkg::t_sample     r_store [MW];
    mmf_pkg::t_mask       r_cand, n_cand;
    logic [CW-1:0]        r_rank, n_rank;
    logic [BCW-1:0]       r_bit;
    logic [SB-1:0]        r_med;
    logic                 r_zero;
    logic                 r_ovalid;
    logic [SB-1:0]        r_odata;

    logic                 in_accept;
    logic                 out_free;
    logic                 load_out;
    logic                 win_ok;
    logic [WB-1:0]        next_slot;
    logic                 sign_step;
    logic                 med_bit;
    mmf_pkg::t_mask       init_cand;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_ovalid || i_m_axis_tready;
    assign win_ok    = (r_win != '0) && (r_win <= WB'(MW));
    assign sign_step = (r_bit == BCW'(SB - 1));

    // Write pointer advances first and wraps when it reaches the window size.
    always_comb begin
        next_slot = r_wslot + WB'(1);
        if (next_slot >= r_win) begin
            next_slot = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < MW; i++) begin
            init_cand[i] = (WB'(i) < r_win);
        end
    end

    // One selection step: look at the current top bit of every candidate.
    // The sign bit is inverted so that negative values order below positive
    // ones. If more candidates carry a zero than the remaining rank, the
    // median has a zero here and the ones drop out; otherwise the zeros drop
    // out and the rank moves past them.
    always_comb begin
        logic [MW-1:0] top;
        logic [CW-1:0] zeros;
        zeros = '0;
        for (int i = 0; i < MW; i++) begin
            top[i] = r_store[i][SB-1] ^ sign_step;
            if (r_cand[i] && !top[i]) begin
                zeros = zeros + CW'(1);
            end
        end
        if (r_rank < zeros) begin
            med_bit = 1'b0;
            n_cand  = r_cand & ~top;
            n_rank  = r_rank;
        end else begin
            med_bit = 1'b1;
            n_cand  = r_cand & top;
            n_rank  = r_rank - zeros;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mmf_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = mmf_pkg::ST_RUN;
                end
            end
            mmf_pkg::ST_RUN: begin
                if (r_bit == '0) begin
                    n_state = mmf_pkg::ST_DONE;
                end
            end
            mmf_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = mmf_pkg::ST_IDLE;
                end
            end
            default: n_state = mmf_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_axis_tready = 1'b0;
        load_out        = 1'b0;
        unique case (r_state)
            mmf_pkg::ST_IDLE: o_s_axis_tready = 1'b1;
            mmf_pkg::ST_RUN:  ;
            mmf_pkg::ST_DONE: load_out = out_free;
            default:          ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mmf_pkg::ST_IDLE;
            r_win    <= mmf_pkg::WIN_RESET;
            r_wslot  <= '0;
            r_ovalid <= 1'b0;
            r_bit    <= '0;
            r_cand   <= '0;
            r_rank   <= '0;
            r_zero   <= 1'b0;
            for (int i = 0; i < MW; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_win <= i_cfg_data;
            end
            if (in_accept) begin
                r_bit  <= BCW'(SB - 1);
                r_zero <= !win_ok;
                r_cand <= init_cand;
                r_rank <= CW'(r_win >> 1);
                if (win_ok) begin
                    r_wslot <= next_slot;
                    for (int i = 0; i < MW; i++) begin
                        if (WB'(i) == next_slot) begin
                            r_store[i] <= i_s_axis_tdata;
                        end
                    end
                end
            end else if (r_state == mmf_pkg::ST_RUN) begin
                // Rotate every entry; after a full pass they are back in place.
                for (int i = 0; i < MW; i++) begin
                    r_store[i] <= {r_store[i][SB-2:0], r_store[i][SB-1]};
                end
                r_cand <= n_cand;
                r_rank <= n_rank;
                r_bit  <= r_bit - BCW'(1);
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result bits arrive from the top down.
    always_ff @(posedge i_clk) begin
        if (r_state == mmf_pkg::ST_RUN) begin
            r_med <= {r_med[SB-2:0], med_bit ^ sign_step};
        end
        if (load_out) begin
            r_odata <= r_zero ? '0 : r_med;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_cfg_ready     = 1'b1;

endmodule

FILE: hdl/mmf_checker.sv
module mmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_cfg_ready
);

    // A stalled output word stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    // Once a sample is taken the filter is busy for the selection pass.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready ##1 !o_s_axis_tready)
        else $error("input taken during selection");

    // A new result appears only as the filter returns to idle.
    a_rise_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("result appeared while busy");

    // The configuration register is always writable.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind moving_median_filter mmf_checker u_mmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_cfg_ready     (o_cfg_ready)
);
